FILE: rtl/ttx_pkg.sv
package ttx_pkg;

    localparam int ENTRIES = 8;

    localparam int ADDR_W  = 24;
    localparam int TIME_W  = 32;
    localparam int ALT_W   = 16;
    localparam int DIST_W  = 16;
    localparam int EXP_W   = 8;
    localparam int VSEP_W  = 15;
    localparam int LEVEL_W = 2;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 4;
    localparam int CFG_A_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_A_W-1:0] CFG_OWN_ADDRESS = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_EXPIRY      = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_VERT_SEP    = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_ZONE_URGENT = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_ZONE_IMPORT = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_ZONE_LOW    = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_ALARM_MODE  = 3'd6;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE      = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW       = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_IMPORTANT = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_URGENT    = 2'd3;

    typedef enum logic {
        REQ_REPORT = 1'b0,
        REQ_SWEEP  = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        ST_UPDATED = 3'd0,
        ST_TOOK    = 3'd1,
        ST_OWN     = 3'd2,
        ST_DROPPED = 3'd3,
        ST_SWEEP   = 3'd4
    } t_status;

    // request token walking down the row of slots
    typedef struct packed {
        logic                valid;
        t_req                req_type;
        logic [ADDR_W-1:0]   addr;
        logic [TIME_W-1:0]   now;
        logic [LEVEL_W-1:0]  level;
        logic                done;
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [CNT_W-1:0]    cleared;
    } t_tok;

endpackage

FILE: rtl/ttx_cell.sv
module ttx_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [ttx_pkg::EXP_W-1:0]     i_expiry,
    input  logic [ttx_pkg::SLOT_W-1:0]    i_slot,
    input  ttx_pkg::t_tok                 i_tok,
    output ttx_pkg::t_tok                 o_tok
);

    logic [ttx_pkg::ADDR_W-1:0] r_addr;
    logic [ttx_pkg::ADDR_W-1:0] n_addr;
    logic [ttx_pkg::TIME_W-1:0] r_time;
    logic [ttx_pkg::TIME_W-1:0] n_time;
    ttx_pkg::t_tok              r_tok;
    ttx_pkg::t_tok              n_tok;

    logic [ttx_pkg::TIME_W-1:0] w_age;
    logic                       w_expired;
    logic                       w_live;
    logic                       w_match;

    always_comb begin
        w_age     = i_tok.now - r_time;
        w_expired = w_age > {{(ttx_pkg::TIME_W-ttx_pkg::EXP_W){1'b0}}, i_expiry};
        w_live    = r_addr != '0;
        w_match   = r_addr == i_tok.addr;

        n_tok  = i_tok;
        n_addr = r_addr;
        n_time = r_time;

        if (i_tok.valid) begin
            if (i_tok.req_type == ttx_pkg::REQ_SWEEP) begin
                if (!w_live || w_expired) begin
                    n_addr = '0;
                    n_time = '0;
                    if (w_live && i_tok.cleared != ttx_pkg::CNT_MAX) begin
                        n_tok.cleared = i_tok.cleared + 1'b1;
                    end
                end
            end else if (!i_tok.done && (w_match || w_expired)) begin
                n_addr       = i_tok.addr;
                n_time       = i_tok.now;
                n_tok.done   = 1'b1;
                n_tok.status = w_match ? ttx_pkg::ST_UPDATED : ttx_pkg::ST_TOOK;
                n_tok.slot   = i_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_time <= '0;
            r_tok  <= '0;
        end else if (i_en) begin
            r_addr <= n_addr;
            r_time <= n_time;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/traffic_table_with_expiry.sv
// traffic table with expiry: tracks up to ENTRIES aircraft, one slot per cell
// input stream (s side): tuser carries the request type (0 report, 1 sweep
// tick), tdata the report fields. one result per request on the m side.
// config channel: i_cfg_valid with i_cfg_addr (register index) and
// i_cfg_data; always ready, write only while no request is in flight.
// a request token walks the row of slot cells, one cell per cycle while the
// row is not held; the first matching or expired slot takes a report, a tick
// clears empty and expired slots on its way. the token is registered in
// each of the ENTRIES cells, then in the result register behind o_m_tvalid;
// a new request is taken only once the previous token has left the row.
// the result register lets the next request enter while a result waits;
// if the receiver stalls with a result pending and a token reaches the end
// of the row, the whole row holds until the result is taken.
// reset empties every slot (address and time zero) and loads the register
// defaults: own address 0, expiry 5 s, separation 300 m, zones 500, 1000 and
// 2000 m, distance alarms on.
module traffic_table_with_expiry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // other_address, now_seconds, other_altitude, own_altitude, other_distance
    input  logic [103:0] i_s_tdata,
    // req_type
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // slot_index, alarm_level, cleared_count, zero fill
    output logic [15:0]  o_m_tdata,
    // status
    output logic [2:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [ttx_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [23:0]  i_cfg_data
);

    logic [ttx_pkg::ADDR_W-1:0] r_own_address;
    logic [ttx_pkg::EXP_W-1:0]  r_expiry;
    logic [ttx_pkg::VSEP_W-1:0] r_vert_sep;
    logic [ttx_pkg::DIST_W-1:0] r_zone_urgent;
    logic [ttx_pkg::DIST_W-1:0] r_zone_import;
    logic [ttx_pkg::DIST_W-1:0] r_zone_low;
    logic                       r_alarm_mode;

    logic                        r_busy;
    logic                        r_out_valid;
    ttx_pkg::t_status            r_out_status;
    logic [ttx_pkg::SLOT_W-1:0]  r_out_slot;
    logic [ttx_pkg::LEVEL_W-1:0] r_out_level;
    logic [ttx_pkg::CNT_W-1:0]   r_out_cleared;

    logic                        w_accept;
    logic                        w_en;
    logic [ttx_pkg::ADDR_W-1:0]  w_addr;
    logic [ttx_pkg::TIME_W-1:0]  w_now;
    logic [ttx_pkg::ALT_W-1:0]   w_other_alt;
    logic [ttx_pkg::ALT_W-1:0]   w_own_alt;
    logic [ttx_pkg::DIST_W-1:0]  w_dist;
    logic [ttx_pkg::ALT_W:0]     w_gap;
    logic [ttx_pkg::ALT_W:0]     w_mag;
    logic [ttx_pkg::LEVEL_W-1:0] w_level;
    logic                        w_own;
    ttx_pkg::t_req               w_req;
    ttx_pkg::t_tok               w_head;
    ttx_pkg::t_tok               w_tok [ttx_pkg::ENTRIES+1];
    ttx_pkg::t_tok               w_tail;
    logic                        w_stored;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = !r_busy;
    assign o_cfg_ready = 1'b1;

    assign w_addr      = i_s_tdata[23:0];
    assign w_now       = i_s_tdata[55:24];
    assign w_other_alt = i_s_tdata[71:56];
    assign w_own_alt   = i_s_tdata[87:72];
    assign w_dist      = i_s_tdata[103:88];
    assign w_req       = ttx_pkg::t_req'(i_s_tuser[0]);

    // distance alarm from altitude gap and zones
    always_comb begin
        w_gap = {w_other_alt[ttx_pkg::ALT_W-1], w_other_alt}
              - {w_own_alt[ttx_pkg::ALT_W-1], w_own_alt};
        w_mag = w_gap[ttx_pkg::ALT_W] ? (~w_gap + 1'b1) : w_gap;
        priority if (!r_alarm_mode
                     || w_mag >= {{(ttx_pkg::ALT_W+1-ttx_pkg::VSEP_W){1'b0}}, r_vert_sep}) begin
            w_level = ttx_pkg::LEVEL_NONE;
        end else if (w_dist < r_zone_urgent) begin
            w_level = ttx_pkg::LEVEL_URGENT;
        end else if (w_dist < r_zone_import) begin
            w_level = ttx_pkg::LEVEL_IMPORTANT;
        end else if (w_dist < r_zone_low) begin
            w_level = ttx_pkg::LEVEL_LOW;
        end else begin
            w_level = ttx_pkg::LEVEL_NONE;
        end
    end

    always_comb begin
        w_own            = w_addr == r_own_address;
        w_head           = '0;
        w_head.valid     = w_accept;
        w_head.req_type  = w_req;
        w_head.addr      = w_addr;
        w_head.now       = w_now;
        w_head.level     = w_level;
        w_head.slot      = '0;
        w_head.cleared   = '0;
        if (w_req == ttx_pkg::REQ_SWEEP) begin
            w_head.done   = 1'b0;
            w_head.status = ttx_pkg::ST_SWEEP;
        end else if (w_own) begin
            w_head.done   = 1'b1;
            w_head.status = ttx_pkg::ST_OWN;
        end else begin
            w_head.done   = 1'b0;
            w_head.status = ttx_pkg::ST_DROPPED;
        end
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < ttx_pkg::ENTRIES; g++) begin : g_cell
        ttx_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_expiry (r_expiry),
            .i_slot   (ttx_pkg::SLOT_W'(g)),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    assign w_tail   = w_tok[ttx_pkg::ENTRIES];
    assign w_en     = !(w_tail.valid && r_out_valid && !i_m_tready);
    assign w_stored = (w_tail.status == ttx_pkg::ST_UPDATED)
                   || (w_tail.status == ttx_pkg::ST_TOOK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
            r_expiry      <= 8'd5;
            r_vert_sep    <= 15'd300;
            r_zone_urgent <= 16'd500;
            r_zone_import <= 16'd1000;
            r_zone_low    <= 16'd2000;
            r_alarm_mode  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                ttx_pkg::CFG_OWN_ADDRESS: r_own_address <= i_cfg_data[ttx_pkg::ADDR_W-1:0];
                ttx_pkg::CFG_EXPIRY:      r_expiry      <= i_cfg_data[ttx_pkg::EXP_W-1:0];
                ttx_pkg::CFG_VERT_SEP:    r_vert_sep    <= i_cfg_data[ttx_pkg::VSEP_W-1:0];
                ttx_pkg::CFG_ZONE_URGENT: r_zone_urgent <= i_cfg_data[ttx_pkg::DIST_W-1:0];
                ttx_pkg::CFG_ZONE_IMPORT: r_zone_import <= i_cfg_data[ttx_pkg::DIST_W-1:0];
                ttx_pkg::CFG_ZONE_LOW:    r_zone_low    <= i_cfg_data[ttx_pkg::DIST_W-1:0];
                ttx_pkg::CFG_ALARM_MODE:  r_alarm_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_en && w_tail.valid) begin
                r_busy <= 1'b0;
            end
            if (w_en && w_tail.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tail.valid) begin
            r_out_status  <= w_tail.status;
            r_out_slot    <= w_tail.slot;
            r_out_level   <= w_stored ? w_tail.level : ttx_pkg::LEVEL_NONE;
            r_out_cleared <= w_tail.cleared;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {7'b0, r_out_cleared, r_out_level, r_out_slot};

endmodule

FILE: tb/sv/tb_traffic_table_with_expiry.sv
module tb_traffic_table_with_expiry;
    import ttx_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int PIPE_LATENCY  = ENTRIES + 1;
    localparam int RX_HOLD_LEN   = 200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int POOL_SIZE     = 12;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   cleared;
    } outcome_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         o_s_tready;
    logic [103:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         o_m_tvalid;
    logic         m_tready;
    logic [15:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         cfg_valid;
    logic         o_cfg_ready;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [23:0]  cfg_data;

    traffic_table_with_expiry i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    // shadow of the aircraft table and its registers
    logic [ADDR_W-1:0]  slot_addr  [ENTRIES];
    logic [TIME_W-1:0]  slot_time  [ENTRIES];
    logic [ALT_W-1:0]   slot_alt   [ENTRIES];
    logic [DIST_W-1:0]  slot_dist  [ENTRIES];
    logic [LEVEL_W-1:0] slot_alarm [ENTRIES];

    logic [ADDR_W-1:0] own_addr_reg;
    logic [EXP_W-1:0]  expiry_reg;
    logic [VSEP_W-1:0] vsep_reg;
    logic [DIST_W-1:0] zone_urgent_reg;
    logic [DIST_W-1:0] zone_important_reg;
    logic [DIST_W-1:0] zone_low_reg;
    logic              alarm_mode_reg;

    outcome_t pending_results[$];

    int fail_count;
    int quiet_cycles;
    int status_seen [5];
    int reports_sent;
    int sweeps_sent;
    int reg_writes;
    int settings_run;

    bit tx_gaps_on;
    bit rx_gaps_on;
    bit rx_hold;
    int rx_stall;

    logic [TIME_W-1:0] time_base;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++) begin
            slot_addr[i]  = '0;
            slot_time[i]  = '0;
            slot_alt[i]   = '0;
            slot_dist[i]  = '0;
            slot_alarm[i] = LEVEL_NONE;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_A_W-1:0] idx, logic [23:0] data);
        case (idx)
            CFG_OWN_ADDRESS: own_addr_reg       = data;
            CFG_EXPIRY:      expiry_reg         = data[EXP_W-1:0];
            CFG_VERT_SEP:    vsep_reg           = data[VSEP_W-1:0];
            CFG_ZONE_URGENT: zone_urgent_reg    = data[DIST_W-1:0];
            CFG_ZONE_IMPORT: zone_important_reg = data[DIST_W-1:0];
            CFG_ZONE_LOW:    zone_low_reg       = data[DIST_W-1:0];
            CFG_ALARM_MODE:  alarm_mode_reg     = data[0];
            default: ;
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] threat_for(logic [ALT_W-1:0] alt_other,
                                                      logic [ALT_W-1:0] alt_own,
                                                      logic [DIST_W-1:0] range_m);
        int gap;
        gap = int'($signed(alt_other)) - int'($signed(alt_own));
        if (gap < 0) gap = -gap;
        if (!alarm_mode_reg || gap >= int'(vsep_reg)) return LEVEL_NONE;
        if (range_m < zone_urgent_reg) return LEVEL_URGENT;
        if (range_m < zone_important_reg) return LEVEL_IMPORTANT;
        if (range_m < zone_low_reg) return LEVEL_LOW;
        return LEVEL_NONE;
    endfunction

    function automatic void predict_request(t_req req, logic [ADDR_W-1:0] addr,
                                            logic [TIME_W-1:0] now,
                                            logic [ALT_W-1:0] alt_other,
                                            logic [ALT_W-1:0] alt_own,
                                            logic [DIST_W-1:0] range_m);
        outcome_t r;
        logic [TIME_W-1:0] age;
        logic live;
        r.status  = ST_DROPPED;
        r.slot    = '0;
        r.level   = LEVEL_NONE;
        r.cleared = '0;
        if (req == REQ_SWEEP) begin
            r.status = ST_SWEEP;
            for (int i = 0; i < ENTRIES; i++) begin
                age  = now - slot_time[i];
                live = slot_addr[i] != '0;
                if (!live || age > expiry_reg) begin
                    if (live && r.cleared != CNT_MAX) r.cleared++;
                    slot_addr[i]  = '0;
                    slot_time[i]  = '0;
                    slot_alt[i]   = '0;
                    slot_dist[i]  = '0;
                    slot_alarm[i] = LEVEL_NONE;
                end
            end
        end else if (addr == own_addr_reg) begin
            r.status = ST_OWN;
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                age = now - slot_time[i];
                if (slot_addr[i] == addr || age > expiry_reg) begin
                    r.status      = (slot_addr[i] == addr) ? ST_UPDATED : ST_TOOK;
                    r.level       = threat_for(alt_other, alt_own, range_m);
                    r.slot        = SLOT_W'(i);
                    slot_addr[i]  = addr;
                    slot_time[i]  = now;
                    slot_alt[i]   = alt_other;
                    slot_dist[i]  = range_m;
                    slot_alarm[i] = r.level;
                    break;
                end
            end
        end
        pending_results.push_back(r);
    endfunction

    function automatic void compare_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // results are checked before new requests are predicted at the same edge
    always @(posedge i_clk) begin
        outcome_t r;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (o_m_tuser < 3'd5) status_seen[o_m_tuser]++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, o_m_tuser);
                    fail_count++;
                end else begin
                    r = pending_results.pop_front();
                    compare_field("status", int'(r.status), int'(o_m_tuser));
                    compare_field("slot_index", int'(r.slot), int'(o_m_tdata[2:0]));
                    compare_field("threat level", int'(r.level), int'(o_m_tdata[4:3]));
                    compare_field("cleared_count", int'(r.cleared), int'(o_m_tdata[8:5]));
                    compare_field("tdata fill", 0, int'(o_m_tdata[15:9]));
                end
            end
            if (cfg_valid && o_cfg_ready) apply_reg(cfg_addr, cfg_data);
            if (s_tvalid && o_s_tready)
                predict_request(t_req'(s_tuser[0]), s_tdata[23:0], s_tdata[55:24],
                                s_tdata[71:56], s_tdata[87:72], s_tdata[103:88]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result receiver: random stalls, or one long hold when asked
    initial begin
        m_tready = 1'b0;
        rx_stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_LEN) @(negedge i_clk);
                rx_hold = 1'b0;
            end else begin
                if (rx_stall == 0 && rx_gaps_on && $urandom_range(0, 99) < 30)
                    rx_stall = pick_gap_len();
                if (rx_stall > 0) begin
                    m_tready <= 1'b0;
                    rx_stall--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(t_req req, logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now,
                             int alt_other, int alt_own, int range_m);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 35) ? pick_gap_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= {DIST_W'(range_m), ALT_W'(alt_own), ALT_W'(alt_other), now, addr};
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        if (req == REQ_SWEEP) sweeps_sent++;
        else reports_sent++;
    endtask

    task automatic stop_requests();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_all_results();
        stop_requests();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [23:0] data);
        @(negedge i_clk);
        cfg_addr  <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_traffic();
        int pick;
        int alt_own;
        int alt_other;
        int dist_top;
        t_req req;
        logic [ADDR_W-1:0] addr;
        req = ($urandom_range(0, 99) < 12) ? REQ_SWEEP : REQ_REPORT;
        pick = $urandom_range(0, 99);
        if (pick >= 95) time_base = $urandom();
        else if (pick >= 85) time_base += $urandom_range(0, int'(expiry_reg) + 3);
        else if (pick >= 45) time_base += $urandom_range(1, 3);
        pick = $urandom_range(0, 99);
        if (pick < 80) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 92) addr = ADDR_W'($urandom_range(0, 24'hFFFFFF));
        else addr = own_addr_reg;
        alt_own = $urandom_range(0, 31000) - 1000;
        if ($urandom_range(0, 99) < 80) begin
            alt_other = alt_own + $urandom_range(0, 2 * int'(vsep_reg) + 100)
                        - (int'(vsep_reg) + 50);
            if (alt_other < -1000) alt_other = -1000;
            if (alt_other > 30000) alt_other = 30000;
        end else begin
            alt_other = $urandom_range(0, 31000) - 1000;
        end
        dist_top = int'(zone_low_reg);
        if (int'(zone_important_reg) > dist_top) dist_top = int'(zone_important_reg);
        if (int'(zone_urgent_reg) > dist_top) dist_top = int'(zone_urgent_reg);
        dist_top = (dist_top + 200 > 65535) ? 65535 : dist_top + 200;
        send_item(req, addr, time_base, alt_other, alt_own,
                  ($urandom_range(0, 99) < 70) ? $urandom_range(0, dist_top)
                                               : $urandom_range(0, 65535));
    endtask

    task automatic run_setting(logic [23:0] own, logic [23:0] expiry, logic [23:0] vsep,
                               logic [23:0] z_urgent, logic [23:0] z_important,
                               logic [23:0] z_low, logic [23:0] mode, int count, bit gaps);
        wait_all_results();
        write_reg(CFG_OWN_ADDRESS, own);
        write_reg(CFG_EXPIRY, expiry);
        write_reg(CFG_VERT_SEP, vsep);
        write_reg(CFG_ZONE_URGENT, z_urgent);
        write_reg(CFG_ZONE_IMPORT, z_important);
        write_reg(CFG_ZONE_LOW, z_low);
        write_reg(CFG_ALARM_MODE, mode);
        settings_run++;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom_range(0, 24'hFFFFFF));
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        if ($urandom_range(0, 3) == 0) time_base = 32'hFFFF_FFF0;
        tx_gaps_on = gaps;
        rx_gaps_on = gaps;
        repeat (count) send_random_traffic();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_reset_state();
        send_item(REQ_REPORT, 24'h123456, 32'd3, 100, 100, 100);
        send_item(REQ_SWEEP, 24'h000000, 32'd3, 0, 0, 0);
        send_item(REQ_REPORT, 24'h000000, 32'd3, 0, 0, 0);
        wait_all_results();
    endtask

    task automatic test_address_zero_and_own();
        write_reg(CFG_OWN_ADDRESS, 24'hABCDEF);
        send_item(REQ_REPORT, 24'h000000, 32'd4, 500, 400, 10);
        send_item(REQ_REPORT, 24'hABCDEF, 32'd4, 500, 400, 10);
    endtask

    task automatic test_fill_and_zones();
        // one slot per distance zone and separation edge, then a full table
        send_item(REQ_REPORT, 24'h000001, 32'd1000, 1299, 1000, 0);
        send_item(REQ_REPORT, 24'h000002, 32'd1000, 701, 1000, 499);
        send_item(REQ_REPORT, 24'h000003, 32'd1000, 1000, 1000, 500);
        send_item(REQ_REPORT, 24'h000004, 32'd1000, 1000, 1000, 999);
        send_item(REQ_REPORT, 24'h000005, 32'd1000, 1000, 1000, 1000);
        send_item(REQ_REPORT, 24'h000006, 32'd1000, 1000, 1000, 1999);
        send_item(REQ_REPORT, 24'h000007, 32'd1000, 1000, 1000, 2000);
        send_item(REQ_REPORT, 24'h000008, 32'd1000, 1300, 1000, 0);
        send_item(REQ_REPORT, 24'h800000, 32'd1002, 1000, 1000, 0);
        send_item(REQ_REPORT, 24'h000004, 32'd1003, -1000, -1000, 65535);
        wait_all_results();
    endtask

    task automatic test_alarm_off_and_sweep();
        write_reg(CFG_ALARM_MODE, 24'd0);
        send_item(REQ_REPORT, 24'h000003, 32'd1004, 1000, 1000, 0);
        send_item(REQ_SWEEP, 24'h000000, 32'd1006, 0, 0, 0);
        wait_all_results();
        write_reg(CFG_ALARM_MODE, 24'd1);
    endtask

    task automatic test_time_wrap();
        send_item(REQ_REPORT, 24'h7FFFFF, 32'hFFFF_FFFF, 30000, -1000, 0);
        send_item(REQ_REPORT, 24'h654321, 32'd2, -1000, -1000, 65535);
        send_item(REQ_SWEEP, 24'hFFFFFF, 32'd3, 30000, 30000, 65535);
        wait_all_results();
    endtask

    task automatic test_register_settings();
        run_setting(24'h5A5A5A, 24'd5, 24'd300, 24'd500, 24'd1000, 24'd2000, 24'd1, 90, 1'b1);
        run_setting(24'h000000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 60, 1'b1);
        run_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    24'hFFFFFF, 80, 1'b0);
        run_setting(24'hA5A5A5, 24'd20, 24'd800, 24'd3000, 24'd1500, 24'd600, 24'd1, 80, 1'b1);
        run_setting(24'h3C3C3C, 24'd3, 24'd500, 24'd500, 24'd1000, 24'd2000, 24'd0, 60, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [23:0] z0;
        for (int p = 0; p < 3; p++) begin
            z0 = 24'($urandom_range(0, 4000));
            run_setting(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 40)),
                        24'($urandom_range(0, 2000)), z0,
                        z0 + 24'($urandom_range(0, 4000)),
                        z0 + 24'($urandom_range(0, 8000)), 24'($urandom_range(0, 1)),
                        70, 1'b1);
        end
    endtask

    task automatic test_backpressure();
        wait_all_results();
        rx_hold    = 1'b1;
        tx_gaps_on = 1'b0;
        repeat (30) send_random_traffic();
        tx_gaps_on = 1'b1;
        wait_all_results();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        rx_hold    = 1'b0;
        time_base  = 32'd2000;
        clear_table();
        own_addr_reg       = '0;
        expiry_reg         = 8'd5;
        vsep_reg           = 15'd300;
        zone_urgent_reg    = 16'd500;
        zone_important_reg = 16'd1000;
        zone_low_reg       = 16'd2000;
        alarm_mode_reg     = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_address_zero_and_own();
        test_fill_and_zones();
        test_alarm_off_and_sweep();
        test_time_wrap();
        test_register_settings();
        test_random_traffic();
        test_backpressure();
        wait_all_results();

        $display("covered %0d reports and %0d sweeps over %0d register settings, %0d writes",
                 reports_sent, sweeps_sent, settings_run, reg_writes);
        $display("results: updated %0d, took slot %0d, own %0d, dropped %0d, sweep %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
